// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mts_pkg.sv =====
// Package of types, codes and default sizes for the MIDI track sequencer.
`timescale 1ns / 1ps

package mts_pkg;

  // Default table sizes.
  localparam int MTS_MEASURES       = 64;
  localparam int MTS_FRAMES         = 256;
  localparam int MTS_SEQUENCE_DEPTH = 128;

  // Request operations.
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_SEQ_WRITE = 2'd1;
  localparam logic [1:0] OP_EV_WRITE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHANNEL         = 2'd0;
  localparam logic [1:0] CFG_MEASURE_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_SEQUENCE_LENGTH = 2'd2;

  // Note kinds.
  localparam logic [1:0] KIND_ON  = 2'd1;
  localparam logic [1:0] KIND_OFF = 2'd2;

  // Status byte high nibbles.
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_PROGRAM  = 4'hC;

  // Bit positions of the pending message set, in emission order.
  localparam int MSG_PROG  = 0;
  localparam int MSG_MUTE  = 1;
  localparam int MSG_NOTE  = 2;
  localparam int MSG_COUNT = 3;

  // Byte counts.
  localparam logic [1:0] LEN_PROGRAM = 2'd2;
  localparam logic [1:0] LEN_NOTE    = 2'd3;

  // Reset value of the measure length register.
  localparam logic [7:0] MEASURE_LENGTH_RST = 8'd120;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEQ_WAIT,
    ST_EV_WAIT,
    ST_EMIT
  } mts_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] sequence_index;
    logic [7:0] sequence_entry;
    logic [5:0] measure_index;
    logic [7:0] frame_index;
    logic [1:0] note_kind;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic       program_valid;
    logic [6:0] program_number;
  } mts_in_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [1:0] byte_count;
    logic       last;
  } mts_out_t;

  // One stored frame event.
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] vel;
    logic       prog_valid;
    logic [6:0] prog;
  } mts_event_t;

endpackage

// ===== hdl/midi_track_sequencer_core.sv =====
// Top level of one MIDI sequencer track: tables, tick sequencing and message output.
`timescale 1ns / 1ps
// Usage
//   in_*  : requests. A tick plays the current frame; a sequence write loads one
//           sequence table entry; an event write loads one (measure, frame) event.
//   out_* : MIDI messages, up to three per tick, the final one marked by last.
//   cfg_* : register writes (channel, measure length, sequence length), always
//           accepted; the user must issue them only while the track is idle, as the block does not enforce it.
// Request handling
//   A write is done as soon as it is taken. A tick that finds the track done
//   leaves it idle. Otherwise the sequence memory is read (and read again after
//   a jump), then the event memory, and then the first message is shown. Each
//   further message is shown in the cycle after the previous is taken. A silent
//   tick that reads the tables returns to idle with no message. The block
//   handles one request at a time, and its two memory reads run in series.
// Reset
//   Reset starts a clearing pass over the event memory, one entry per cycle,
//   over all MEASURES*FRAMES entries (16384 by default), during which in_ready is low.
// Stall
//   A message stays on out_data while out_ready is low; no request is taken
//   until the last message of the tick has gone.

module midi_track_sequencer_core
  import mts_pkg::*;
#(
  parameter int MEASURES       = MTS_MEASURES,
  parameter int FRAMES         = MTS_FRAMES,
  parameter int SEQUENCE_DEPTH = MTS_SEQUENCE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mts_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output mts_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int EV_DEPTH = MEASURES * FRAMES;
  localparam int EV_AW    = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;
  localparam int SEQ_AW   = (SEQUENCE_DEPTH > 1) ? $clog2(SEQUENCE_DEPTH) : 1;

  // Configuration registers.
  logic [3:0] channel_r;
  logic [7:0] meas_len_r;
  logic [7:0] seq_len_r;

  // Track state.
  mts_state_t             state_r, state_nxt;
  logic [7:0]             pos_r, pos_nxt;
  logic [7:0]             frame_r, frame_nxt;
  logic [6:0]             sound_r, sound_nxt;
  logic                   jumped_r, jumped_nxt;
  logic [MSG_COUNT-1:0]   pend_r, pend_nxt;
  logic [EV_AW-1:0]       clr_r, clr_nxt;

  // Memories and their ports.
  logic [7:0]        seq_mem [SEQUENCE_DEPTH];
  mts_event_t        ev_mem  [EV_DEPTH];
  logic              seq_we, seq_re;
  logic [SEQ_AW-1:0] seq_waddr, seq_raddr;
  logic [7:0]        seq_wdata, seq_rdata_r;
  logic              ev_we, ev_re;
  logic [EV_AW-1:0]  ev_waddr, ev_raddr;
  mts_event_t        ev_wdata, ev_rdata_r;

  // Message selection.
  logic [MSG_COUNT-1:0] sel;
  logic [MSG_COUNT-1:0] pend_left;

  // Track is done when the position runs past the sequence.
  function automatic logic is_done(input logic [7:0] pos, input logic [7:0] len);
    is_done = (pos >= len) || (32'(pos) >= SEQUENCE_DEPTH);
  endfunction

  // Event memory address of a measure and frame.
  function automatic logic [EV_AW-1:0] ev_addr(input logic [7:0] m, input logic [7:0] f);
    ev_addr = EV_AW'(32'(m) * FRAMES + 32'(f));
  endfunction

  assign cfg_ready = 1'b1;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r  <= '0;
      meas_len_r <= MEASURE_LENGTH_RST;
      seq_len_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL:         channel_r  <= cfg_data[3:0];
        CFG_MEASURE_LENGTH:  meas_len_r <= cfg_data;
        CFG_SEQUENCE_LENGTH: seq_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence memory, undefined until written.
  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[seq_waddr] <= seq_wdata;
    end
    if (seq_re) begin
      seq_rdata_r <= seq_mem[seq_raddr];
    end
  end

  // Event memory, cleared by the sweep after reset.
  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_waddr] <= ev_wdata;
    end
    if (ev_re) begin
      ev_rdata_r <= ev_mem[ev_raddr];
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      pos_r    <= '0;
      frame_r  <= '0;
      sound_r  <= '0;
      jumped_r <= 1'b0;
      pend_r   <= '0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      frame_r  <= frame_nxt;
      sound_r  <= sound_nxt;
      jumped_r <= jumped_nxt;
      pend_r   <= pend_nxt;
      clr_r    <= clr_nxt;
    end
  end

  // Lowest pending message goes first.
  assign sel       = pend_r & (~pend_r + MSG_COUNT'(1));
  assign pend_left = pend_r & ~sel;

  // Message payload, built from the registered event and state.
  always_comb begin
    out_data = '0;
    if (sel[MSG_PROG]) begin
      out_data.status_byte = {STAT_PROGRAM, channel_r};
      out_data.data_first  = ev_rdata_r.prog;
      out_data.byte_count  = LEN_PROGRAM;
    end else if (sel[MSG_MUTE]) begin
      out_data.status_byte = {STAT_NOTE_OFF, channel_r};
      out_data.data_first  = sound_r;
      out_data.byte_count  = LEN_NOTE;
    end else begin
      out_data.status_byte = {(ev_rdata_r.kind == KIND_ON) ? STAT_NOTE_ON : STAT_NOTE_OFF,
                              channel_r};
      out_data.data_first  = ev_rdata_r.note;
      out_data.data_second = ev_rdata_r.vel;
      out_data.byte_count  = LEN_NOTE;
    end
    out_data.last = (pend_left == '0);
  end

  // Next state, memory ports and handshakes.
  always_comb begin
    logic [7:0]           pos_w;
    logic [7:0]           frame_w;
    logic [MSG_COUNT-1:0] pend_w;

    state_nxt  = state_r;
    pos_nxt    = pos_r;
    frame_nxt  = frame_r;
    sound_nxt  = sound_r;
    jumped_nxt = jumped_r;
    pend_nxt   = pend_r;
    clr_nxt    = clr_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    seq_we     = 1'b0;
    seq_re     = 1'b0;
    seq_waddr  = in_data.sequence_index[SEQ_AW-1:0];
    seq_wdata  = in_data.sequence_entry;
    seq_raddr  = pos_r[SEQ_AW-1:0];
    ev_we      = 1'b0;
    ev_re      = 1'b0;
    ev_waddr   = clr_r;
    ev_wdata   = '0;
    ev_raddr   = ev_addr(seq_rdata_r, frame_r);
    pos_w      = pos_r;
    frame_w    = frame_r;
    pend_w     = '0;

    case (state_r)
      ST_CLEAR: begin
        ev_we   = 1'b1;
        clr_nxt = clr_r + EV_AW'(1);
        if (clr_r == EV_AW'(EV_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.operation)
            OP_TICK: begin
              // Wrap the frame counter at the measure length.
              if (frame_r >= meas_len_r) begin
                frame_w = '0;
                pos_w   = (pos_r == 8'hFF) ? pos_r : pos_r + 8'd1;
              end
              pos_nxt   = pos_w;
              frame_nxt = frame_w;
              if (!is_done(pos_w, seq_len_r)) begin
                seq_re     = 1'b1;
                seq_raddr  = pos_w[SEQ_AW-1:0];
                jumped_nxt = 1'b0;
                state_nxt  = ST_SEQ_WAIT;
              end
            end
            OP_SEQ_WRITE: begin
              if (32'(in_data.sequence_index) < SEQUENCE_DEPTH) begin
                seq_we = 1'b1;
              end
            end
            OP_EV_WRITE: begin
              if (32'(in_data.measure_index) < MEASURES &&
                  32'(in_data.frame_index) < FRAMES) begin
                ev_we               = 1'b1;
                ev_waddr            = ev_addr({2'b00, in_data.measure_index},
                                              in_data.frame_index);
                ev_wdata.kind       = in_data.note_kind;
                ev_wdata.note       = in_data.note_number;
                ev_wdata.vel        = in_data.note_velocity;
                ev_wdata.prog_valid = in_data.program_valid;
                ev_wdata.prog       = in_data.program_number;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SEQ_WAIT: begin
        if (seq_rdata_r[7] && !jumped_r) begin
          // Jump to another sequence position, checked again for the end.
          pos_w   = {1'b0, seq_rdata_r[6:0]};
          pos_nxt = pos_w;
          if (is_done(pos_w, seq_len_r)) begin
            state_nxt = ST_IDLE;
          end else begin
            seq_re     = 1'b1;
            seq_raddr  = pos_w[SEQ_AW-1:0];
            jumped_nxt = 1'b1;
          end
        end else if (32'(seq_rdata_r) < MEASURES && 32'(frame_r) < FRAMES) begin
          ev_re     = 1'b1;
          state_nxt = ST_EV_WAIT;
        end else begin
          // Measure out of range: a silent frame.
          frame_nxt = frame_r + 8'd1;
          state_nxt = ST_IDLE;
        end
      end

      ST_EV_WAIT: begin
        pend_w[MSG_PROG] = ev_rdata_r.prog_valid;
        pend_w[MSG_MUTE] = (ev_rdata_r.kind == KIND_ON) && (sound_r != 7'd0);
        pend_w[MSG_NOTE] = (ev_rdata_r.kind == KIND_ON) || (ev_rdata_r.kind == KIND_OFF);
        pend_nxt = pend_w;
        if (pend_w == '0) begin
          frame_nxt = frame_r + 8'd1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          pend_nxt = pend_left;
          if (pend_left == '0) begin
            // Tick complete: update the sounding note and advance the frame.
            if (ev_rdata_r.kind == KIND_ON) begin
              sound_nxt = ev_rdata_r.note;
            end else if (ev_rdata_r.kind == KIND_OFF) begin
              sound_nxt = 7'd0;
            end
            frame_nxt = frame_r + 8'd1;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mts_checker.sv =====
// Port-level checker for the MIDI track sequencer, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mts_checker
  import mts_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input mts_out_t out_data
);

  // A stalled message holds.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled message changed")

  // No request is taken while a message is waiting.
  `ASSERT_CLK(a_no_overlap, out_valid |-> !in_ready, "request taken during message output")

  // Messages of one tick follow without a gap until the last.
  `ASSERT_CLK(a_burst, out_valid && out_ready && !out_data.last |=> out_valid, "gap inside message burst")

  // Program changes are two bytes, note messages three.
  `ASSERT_CLK(a_length, out_valid |-> ((out_data.status_byte[7:4] == STAT_PROGRAM) == (out_data.byte_count == LEN_PROGRAM)), "byte count does not match status")

  // After reset the block is clearing and shows nothing.
  `ASSERT_CLK_RST(a_reset, !rst_n |=> !out_valid && !in_ready, "activity straight after reset")

endmodule

bind midi_track_sequencer_core mts_checker u_mts_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the MIDI track sequencer core.
`timescale 1ns / 1ps

module testbench;
  import mts_pkg::*;

  // Run limits and codes that the package does not name.
  localparam int         CYCLE_LIMIT  = 250000;
  localparam int         QUIET_CYCLES = 8;
  localparam logic [1:0] OP_IGNORED   = 2'd3;
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [7:0] JUMP_FLAG    = 8'h80;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  mts_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  mts_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  midi_track_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the track: registers, play state and both tables.
  logic [3:0] chan_reg;
  logic [7:0] mlen_reg;
  logic [7:0] slen_reg;
  logic [7:0] play_pos;
  logic [7:0] frame_cnt;
  logic [6:0] sounding;
  logic [7:0] seq_tab [MTS_SEQUENCE_DEPTH];
  bit         seq_written [MTS_SEQUENCE_DEPTH];
  mts_event_t ev_tab [MTS_MEASURES * MTS_FRAMES];

  // MIDI messages still owed by the track, oldest first.
  mts_out_t   midi_expected [$];

  bit         steady;
  logic [6:0] loop_home;
  int         failures;
  int         requests_sent;
  int         ticks_sent;
  int         msgs_seen;
  int         cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor.

  function automatic bit track_done(logic [7:0] pos);
    return (pos >= slen_reg) || (pos >= MTS_SEQUENCE_DEPTH);
  endfunction

  function automatic mts_out_t make_msg(logic [3:0] nib, logic [6:0] d_one,
                                        logic [6:0] d_two, logic [1:0] len);
    mts_out_t m;
    m.status_byte = {nib, chan_reg};
    m.data_first  = d_one;
    m.data_second = d_two;
    m.byte_count  = len;
    m.last        = 1'b0;
    return m;
  endfunction

  // One tick: wrap the frame, follow a jump, then play the event of the frame.
  function automatic void predict_tick();
    logic [7:0] entry;
    mts_event_t ev;
    mts_out_t   msg [3];
    int         n;
    n  = 0;
    ev = '0;
    if (frame_cnt >= mlen_reg) begin
      frame_cnt = '0;
      if (play_pos != 8'hff) play_pos = play_pos + 8'd1;
    end
    if (track_done(play_pos)) return;
    entry = seq_tab[play_pos[6:0]];
    if (entry[7]) begin
      play_pos = {1'b0, entry[6:0]};
      if (track_done(play_pos)) return;
      entry = seq_tab[play_pos[6:0]];
    end
    // A chained jump leaves bit 7 set, so it lands among the bad measures.
    if (entry < MTS_MEASURES && frame_cnt < MTS_FRAMES)
      ev = ev_tab[int'(entry) * MTS_FRAMES + int'(frame_cnt)];
    if (ev.prog_valid) begin
      msg[n] = make_msg(STAT_PROGRAM, ev.prog, '0, LEN_PROGRAM);
      n++;
    end
    if (ev.kind == KIND_ON) begin
      if (sounding != '0) begin
        msg[n] = make_msg(STAT_NOTE_OFF, sounding, '0, LEN_NOTE);
        n++;
      end
      msg[n] = make_msg(STAT_NOTE_ON, ev.note, ev.vel, LEN_NOTE);
      n++;
      sounding = ev.note;
    end else if (ev.kind == KIND_OFF) begin
      msg[n] = make_msg(STAT_NOTE_OFF, ev.note, ev.vel, LEN_NOTE);
      n++;
      sounding = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) msg[i].last = 1'b1;
      midi_expected.push_back(msg[i]);
    end
    frame_cnt = frame_cnt + 8'd1;
  endfunction

  function automatic void predict_request(mts_in_t r);
    mts_event_t ev;
    case (r.operation)
      OP_TICK: predict_tick();
      OP_SEQ_WRITE: begin
        seq_tab[r.sequence_index]     = r.sequence_entry;
        seq_written[r.sequence_index] = 1'b1;
      end
      OP_EV_WRITE: begin
        ev.kind       = r.note_kind;
        ev.note       = r.note_number;
        ev.vel        = r.note_velocity;
        ev.prog_valid = r.program_valid;
        ev.prog       = r.program_number;
        if (r.measure_index < MTS_MEASURES && r.frame_index < MTS_FRAMES)
          ev_tab[int'(r.measure_index) * MTS_FRAMES + int'(r.frame_index)] = ev;
      end
      default: ;
    endcase
  endfunction

  // Sequence entry that the next tick would read before anything wrote it, or -1.
  function automatic int unread_entry();
    logic [7:0] pos;
    logic [7:0] entry;
    pos = play_pos;
    if (frame_cnt >= mlen_reg && pos != 8'hff) pos = pos + 8'd1;
    if (track_done(pos)) return -1;
    if (!seq_written[pos[6:0]]) return int'(pos);
    entry = seq_tab[pos[6:0]];
    if (!entry[7]) return -1;
    pos = {1'b0, entry[6:0]};
    if (track_done(pos) || seq_written[pos[6:0]]) return -1;
    return int'(pos);
  endfunction

  // Request generation.

  function automatic mts_in_t random_request();
    logic [63:0] bits;
    mts_in_t     r;
    bits = {$urandom, $urandom};
    r    = bits[$bits(mts_in_t)-1:0];
    return r;
  endfunction

  function automatic mts_in_t random_event(logic [5:0] m, logic [7:0] f);
    mts_in_t r;
    int      pick;
    r               = random_request();
    r.operation     = OP_EV_WRITE;
    r.measure_index = m;
    r.frame_index   = f;
    pick            = $urandom_range(99);
    r.note_kind     = (pick < 45) ? KIND_ON : (pick < 70) ? KIND_OFF :
                      (pick < 85) ? KIND_NONE : KIND_UNUSED;
    pick = $urandom_range(9);
    if (pick == 0) r.note_number = '0;
    else if (pick == 1) r.note_number = 7'h7f;
    r.program_valid = ($urandom_range(99) < 35);
    return r;
  endfunction

  function automatic void log_mismatch(string text);
    failures++;
    if (failures <= 10) $display("%s", text);
  endfunction

  // Request driver: optional gap, then hold the request until it is taken.
  task automatic send_request(mts_in_t req);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_request(req);
    if (req.operation != OP_IGNORED) requests_sent++;
    if (req.operation == OP_TICK) ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_sequence_entry(logic [6:0] idx, logic [7:0] value);
    mts_in_t req;
    req                = random_request();
    req.operation      = OP_SEQ_WRITE;
    req.sequence_index = idx;
    req.sequence_entry = value;
    send_request(req);
  endtask

  task automatic write_event(logic [5:0] m, logic [7:0] f, logic [1:0] kind,
                             logic [6:0] note, logic [6:0] vel, logic pv,
                             logic [6:0] prog);
    mts_in_t req;
    req                = random_request();
    req.operation      = OP_EV_WRITE;
    req.measure_index  = m;
    req.frame_index    = f;
    req.note_kind      = kind;
    req.note_number    = note;
    req.note_velocity  = vel;
    req.program_valid  = pv;
    req.program_number = prog;
    send_request(req);
  endtask

  // A tick, preceded by writes of any sequence entry it would otherwise read blind.
  task automatic send_tick();
    mts_in_t req;
    int      idx;
    idx = unread_entry();
    while (idx >= 0) begin
      if (idx > int'(loop_home) && seq_written[loop_home])
        write_sequence_entry(idx[6:0], JUMP_FLAG | {1'b0, loop_home});
      else
        write_sequence_entry(idx[6:0], 8'($urandom_range(63)));
      idx = unread_entry();
    end
    req           = random_request();
    req.operation = OP_TICK;
    send_request(req);
  endtask

  // Stop sending until every owed message has come, then let the track settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (midi_expected.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic hold_until_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (midi_expected.size() != 0);
  endtask

  // Register writes keep the valid high across a run of writes.
  task automatic write_register(logic [1:0] idx, logic [7:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CHANNEL:         chan_reg = value[3:0];
      CFG_MEASURE_LENGTH:  mlen_reg = value;
      CFG_SEQUENCE_LENGTH: slen_reg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure_track(logic [3:0] ch, logic [7:0] ml, logic [7:0] sl);
    write_register(CFG_CHANNEL, {4'h0, ch});
    write_register(CFG_MEASURE_LENGTH, ml);
    write_register(CFG_SEQUENCE_LENGTH, sl);
    cfg_valid <= 1'b0;
  endtask

  // One song: a short looping sequence from the current position, events in a
  // few measures, then mostly ticks mixed with rewrites and noise.
  task automatic play_song(int n_items, bit hold_each, bit full_sequence);
    logic [7:0] start;
    logic [7:0] ml;
    logic [7:0] sl;
    logic [5:0] pool [3];
    int         span;
    int         nf;
    int         pick;
    int         base;
    logic [7:0] value;
    mts_in_t    req;
    wait_idle();
    start = play_pos;
    span  = $urandom_range(2, 6);
    if (int'(start) + span > MTS_SEQUENCE_DEPTH) span = MTS_SEQUENCE_DEPTH - int'(start);
    if (span < 0) span = 0;
    pick = $urandom_range(99);
    ml   = (pick < 10) ? 8'd255 : (pick < 20) ? 8'd1 : 8'($urandom_range(2, 6));
    sl   = (full_sequence || $urandom_range(99) < 15) ? 8'd128 : 8'(int'(start) + span);
    loop_home = start[6:0];
    for (int k = 0; k < 3; k++) pool[k] = 6'($urandom_range(63));
    configure_track(4'($urandom_range(15)), ml, sl);
    base = requests_sent;

    // Sequence entries: measures from the pool, a few bad measures and jumps;
    // the last entry usually loops back to the start.
    for (int i = 0; i < span; i++) begin
      pick = $urandom_range(99);
      if (i == span - 1) begin
        if (pick < 70) value = JUMP_FLAG | start;
        else if (pick < 85) value = {2'b00, pool[$urandom_range(2)]};
        else value = JUMP_FLAG | 8'(int'(start) + $urandom_range(span - 1));
      end else begin
        if (pick < 10) value = 8'($urandom_range(64, 127));
        else if (pick < 20) value = JUMP_FLAG | 8'(int'(start) + $urandom_range(span - 1));
        else value = {2'b00, pool[$urandom_range(2)]};
      end
      write_sequence_entry(7'(int'(start) + i), value);
    end

    nf = (ml < 6) ? int'(ml) : 6;
    for (int k = 0; k < 3; k++)
      for (int f = 0; f < nf; f++)
        send_request(random_event(pool[k], 8'(f)));

    while (requests_sent - base < n_items) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_tick();
        if (hold_each) hold_until_quiet();
      end else if (pick < 86) begin
        send_request(random_event(pool[$urandom_range(2)], 8'($urandom_range(nf - 1))));
      end else if (pick < 93) begin
        send_request(random_event(6'($urandom_range(63)), 8'($urandom_range(255))));
      end else if (pick < 97) begin
        if (int'(start) + span <= MTS_SEQUENCE_DEPTH - 1)
          write_sequence_entry(7'($urandom_range(int'(start) + span, 127)),
                               8'($urandom_range(255)));
      end else begin
        req           = random_request();
        req.operation = OP_IGNORED;
        send_request(req);
      end
    end
  endtask

  // Tests.

  // Ticks with the reset settings and with an empty sequence find the track done.
  task automatic test_reset_defaults();
    mts_in_t req;
    send_tick();
    req           = random_request();
    req.operation = OP_IGNORED;
    send_request(req);
    wait_idle();
    configure_track(4'h0, 8'd255, 8'd0);
    send_tick();
  endtask

  // Hand-built sequence: program changes, an implied note-off, note zero,
  // an explicit note-off, the unused note kind, a chained jump, a bad measure
  // and the end of the sequence.
  task automatic test_directed_playback();
    wait_idle();
    configure_track(4'hf, 8'd5, 8'd5);
    write_sequence_entry(7'd0, 8'd63);
    write_sequence_entry(7'd1, JUMP_FLAG | 8'd3);
    write_sequence_entry(7'd3, JUMP_FLAG | 8'd2);
    write_sequence_entry(7'd4, 8'd100);
    write_event(6'd63, 8'd0, KIND_ON, 7'd0, 7'd127, 1'b1, 7'd127);
    write_event(6'd63, 8'd1, KIND_ON, 7'd127, 7'd1, 1'b0, 7'd0);
    write_event(6'd63, 8'd2, KIND_ON, 7'd5, 7'd0, 1'b1, 7'd0);
    write_event(6'd63, 8'd3, KIND_OFF, 7'd5, 7'd64, 1'b0, 7'd0);
    write_event(6'd63, 8'd4, KIND_UNUSED, 7'd33, 7'd9, 1'b0, 7'd0);
    repeat (5) send_tick();
    wait_idle();
    write_register(CFG_MEASURE_LENGTH, 8'd1);
    cfg_valid <= 1'b0;
    repeat (3) send_tick();
  endtask

  task automatic test_random_songs();
    repeat (5) play_song(70, 1'b0, 1'b0);
  endtask

  // Neither side idles here.
  task automatic test_steady_stream();
    steady = 1'b1;
    play_song(60, 1'b0, 1'b1);
    wait_idle();
    steady = 1'b0;
  endtask

  // The sender waits for each tick's messages before the next request.
  task automatic test_paced_ticks();
    play_song(50, 1'b1, 1'b0);
  endtask

  // Result checker.
  always @(posedge clk) begin : check_midi
    mts_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (midi_expected.size() == 0) begin
        log_mismatch($sformatf("Unexpected message: status %h data %0d/%0d count %0d last %b",
                               out_data.status_byte, out_data.data_first,
                               out_data.data_second, out_data.byte_count, out_data.last));
      end else begin
        want = midi_expected.pop_front();
        msgs_seen++;
        if (out_data.status_byte !== want.status_byte ||
            out_data.data_first  !== want.data_first  ||
            out_data.data_second !== want.data_second ||
            out_data.byte_count  !== want.byte_count  ||
            out_data.last        !== want.last) begin
          log_mismatch($sformatf(
            "Message %0d: expected %h %0d/%0d n%0d last %b, got %h %0d/%0d n%0d last %b",
            msgs_seen, want.status_byte, want.data_first, want.data_second,
            want.byte_count, want.last, out_data.status_byte, out_data.data_first,
            out_data.data_second, out_data.byte_count, out_data.last));
        end
      end
    end
  end

  // Result receiver: random stalls except in the steady stretch.
  always @(negedge clk) begin
    if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 28);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d messages outstanding.", midi_expected.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    chan_reg  = '0;
    mlen_reg  = MEASURE_LENGTH_RST;
    slen_reg  = '0;
    play_pos  = '0;
    frame_cnt = '0;
    sounding  = '0;
    loop_home = '0;
    for (int i = 0; i < MTS_SEQUENCE_DEPTH; i++) begin
      seq_tab[i]     = '0;
      seq_written[i] = 1'b0;
    end
    for (int i = 0; i < MTS_MEASURES * MTS_FRAMES; i++) ev_tab[i] = '0;
    steady        = 1'b0;
    failures      = 0;
    requests_sent = 0;
    ticks_sent    = 0;
    msgs_seen     = 0;
    cycle_count   = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_directed_playback();
    test_random_songs();
    test_steady_stream();
    test_paced_ticks();
    wait_idle();

    $display("Sent %0d requests (%0d ticks) and checked %0d MIDI messages.",
             requests_sent, ticks_sent, msgs_seen);
    $display("Covered %s; %0d failures.",
             "hand-built playback, random looping songs, a stall-free run and paced ticks",
             failures);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
